/* design/wkv_pkg.sv */
// Package for the WKV recurrence step core: fixed-point constants, state
// machine types, the saturation helper and the reciprocal table for the exp unit.
// No dependencies; used by every module of the core but wkv_ram.
package wkv_pkg;

  // Fixed-point format of every value.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  // Exponent arguments, the differences of the terms and their maxima, are kept at this width.
  localparam int ARG_W     = 34;
  // e^x result: unsigned, FRAC_BITS fraction bits, 1.0 included.
  localparam int EXP_W     = FRAC_BITS + 1;
  // Products e*x and their sums.
  localparam int SUM_W     = 51;
  // Divider widths: dividend magnitude and divisor.
  localparam int DIV_NW    = 50;
  localparam int DIV_DW    = 34;

  // Exp unit constants (Q2.30).
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [22:0] EXP_A_MAX = 23'(64 << FRAC_BITS);
  localparam int          FRAC_GAP  = 30 - FRAC_BITS;

  // Item actions.
  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Channel state word: {running exponent, denominator, numerator}.
  localparam int          WORD_W     = 3 * DATA_W;
  localparam logic [95:0] RESET_WORD = {32'h8000_0000, 32'h0, 32'h0};

  typedef struct packed {
    logic               flag;
    logic signed [31:0] val;
  } sat_t;

  typedef enum logic [3:0] {
    E_IDLE, E_LOG, E_SPLIT, E_ZLATCH, E_MZP, E_MREC, E_FIX, E_OUT
  } exp_state_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_QUOT, S_ADDR, S_READ, S_ARG, S_ARG2, S_EXPGO, S_EXPW,
    S_MACINIT, S_MUL, S_ACC, S_DIVGO, S_DIVW, S_OUT, S_CLRW
  } core_state_t;

  // Saturate a signed value to 32 bits and report whether it was clipped.
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    begin
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
        r.flag = 1'b1;
        r.val  = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
        r.flag = 1'b1;
        r.val  = -32'sh8000_0000;
      end else begin
        r.flag = 1'b0;
        r.val  = v[31:0];
      end
      return r;
    end
  endfunction

  // floor(2^32 / j) for j = 1..8, clipped to 32 bits.
  function automatic logic [31:0] recip(input logic [3:0] j);
    logic [31:0] r;
    begin
      case (j)
        4'd1:    r = 32'hFFFF_FFFF;
        4'd2:    r = 32'h8000_0000;
        4'd3:    r = 32'h5555_5555;
        4'd4:    r = 32'h4000_0000;
        4'd5:    r = 32'h3333_3333;
        4'd6:    r = 32'h2AAA_AAAA;
        4'd7:    r = 32'h2492_4924;
        4'd8:    r = 32'h2000_0000;
        default: r = 32'hFFFF_FFFF;
      endcase
      return r;
    end
  endfunction

endpackage

/* design/wkv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wkv_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/wkv_exp.sv */
// Iterative exponential unit: e^x for x <= 0 with one shared multiplier,
// a range split into 2^-ip * e^(-frac) and an eight-term series for e^(-frac).
// Depends on wkv_pkg.
module wkv_exp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [wkv_pkg::ARG_W-1:0]   arg,
  output logic                               done,
  output logic [wkv_pkg::EXP_W-1:0]          result
);

  localparam int ARG_W_L = wkv_pkg::ARG_W;

  wkv_pkg::exp_state_t state, state_next;

  logic [22:0] a;
  logic [63:0] prod;
  logic [7:0]  ip;
  logic [29:0] z;
  logic [30:0] p;
  logic [29:0] t;
  logic [3:0]  j;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [ARG_W_L-1:0] neg;
  logic [22:0] a_c;
  logic [23:0] y;
  logic [7:0]  ip_c;
  logic [29:0] r_c;
  logic [29:0] t_c;
  logic [31:0] q0;
  logic [35:0] qj;
  logic [31:0] rem;
  logic [31:0] q;
  logic [4:0]  s;
  logic [31:0] rnd;

  // Clamp -x to the largest argument that still matters.
  assign neg = arg[ARG_W_L-1] ? ARG_W_L'(-arg) : '0;
  assign a_c = (neg > ARG_W_L'(wkv_pkg::EXP_A_MAX)) ? wkv_pkg::EXP_A_MAX : neg[22:0];

  // Split of y = a*log2(e) into integer and fraction parts.
  assign y    = prod[53:30];
  assign ip_c = y[23:16];
  assign r_c  = 30'({y[wkv_pkg::FRAC_BITS-1:0], {wkv_pkg::FRAC_GAP{1'b0}}});

  // Series step: t / j through a reciprocal product and one correction.
  assign t_c  = prod[59:30];
  assign q0   = prod[63:32];
  assign qj   = 36'(q0) * 36'(j);
  assign rem  = 32'(t) - qj[31:0];
  assign q    = (rem >= 32'(j)) ? q0 + 32'd1 : q0;

  // Final rounding shift by FRAC_GAP + ip.
  assign s    = 5'(wkv_pkg::FRAC_GAP) + ip[4:0];
  assign rnd  = (32'(p) + (32'd1 << (s - 5'd1))) >> s;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      wkv_pkg::E_LOG:   begin mul_a = 32'(a);  mul_b = 32'(wkv_pkg::LOG2E_Q30); end
      wkv_pkg::E_SPLIT: begin mul_a = 32'(r_c); mul_b = 32'(wkv_pkg::LN2_Q30); end
      wkv_pkg::E_MZP:   begin mul_a = 32'(z);  mul_b = 32'(p); end
      wkv_pkg::E_MREC:  begin mul_a = 32'(t_c); mul_b = wkv_pkg::recip(j); end
      default:          begin mul_a = '0;      mul_b = '0; end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wkv_pkg::E_IDLE:   if (start) state_next = wkv_pkg::E_LOG;
      wkv_pkg::E_LOG:    state_next = wkv_pkg::E_SPLIT;
      wkv_pkg::E_SPLIT: begin
        if (ip_c > 8'(wkv_pkg::FRAC_BITS)) state_next = wkv_pkg::E_IDLE;
        else state_next = wkv_pkg::E_ZLATCH;
      end
      wkv_pkg::E_ZLATCH: state_next = wkv_pkg::E_MZP;
      wkv_pkg::E_MZP:    state_next = wkv_pkg::E_MREC;
      wkv_pkg::E_MREC:   state_next = wkv_pkg::E_FIX;
      wkv_pkg::E_FIX: begin
        if (j == 4'd1) state_next = wkv_pkg::E_OUT;
        else state_next = wkv_pkg::E_MZP;
      end
      wkv_pkg::E_OUT:    state_next = wkv_pkg::E_IDLE;
      default:           state_next = wkv_pkg::E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wkv_pkg::E_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == wkv_pkg::E_SPLIT) && (ip_c > 8'(wkv_pkg::FRAC_BITS)))
               || (state == wkv_pkg::E_OUT);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      wkv_pkg::E_IDLE: begin
        a <= a_c;
      end
      wkv_pkg::E_LOG: begin
        prod <= mul_p;
      end
      wkv_pkg::E_SPLIT: begin
        ip     <= ip_c;
        prod   <= mul_p;
        result <= '0;
      end
      wkv_pkg::E_ZLATCH: begin
        z <= prod[59:30];
        p <= wkv_pkg::ONE_Q30;
        j <= 4'd8;
      end
      wkv_pkg::E_MZP: begin
        prod <= mul_p;
      end
      wkv_pkg::E_MREC: begin
        t    <= t_c;
        prod <= mul_p;
      end
      wkv_pkg::E_FIX: begin
        p <= wkv_pkg::ONE_Q30 - q[30:0];
        j <= j - 4'd1;
      end
      wkv_pkg::E_OUT: begin
        result <= rnd[wkv_pkg::EXP_W-1:0];
      end
      default: begin
        a <= a;
      end
    endcase
  end

endmodule

/* design/wkv_div.sv */
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on wkv_pkg for the operand widths.
module wkv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wkv_pkg::DIV_NW-1:0]    dividend,
  input  logic [wkv_pkg::DIV_DW-1:0]    divisor,
  output logic                          done,
  output logic [wkv_pkg::DIV_NW-1:0]    quotient
);

  localparam int NW = wkv_pkg::DIV_NW;
  localparam int DW = wkv_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW-1:0] dsr;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shifted  = {rem[DW-1:0], quotient[NW-1]};
  assign diff     = shifted - {1'b0, dsr};
  assign fits     = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(NW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      rem      <= fits ? diff : shifted;
      quotient <= {quotient[NW-2:0], fits};
    end
  end

endmodule

/* design/wkv_recurrence_step_core.sv */
// Top level of the WKV recurrence step core: channel state RAM, sequencer,
// shared exp unit, 18x32 multiply-accumulate and serial divider.
// Depends on wkv_pkg, wkv_ram, wkv_exp and wkv_div.
//
//  Channel  | Ports                                              | Transfer
//  ---------+----------------------------------------------------+--------------------
//  command  | start, busy, action, channel, key_in, value_in,    | start high, busy low
//           | bonus, decay                                       |
//  result   | done, channel_out, wkv_out, saturated              | done high, one cycle
//
// A step item holds busy through five setup states, four exp passes (a pass ends early
// when the argument underflows; the larger term of each pair always runs the eight-term
// series), the multiply-accumulate sequence, the divider and the write-back state S_OUT.
// done comes in the first idle cycle. A clear item holds busy through S_QUOT, S_ADDR and
// S_CLRW. After reset the state RAM is swept over all CHANNELS entries with busy high.
// Results cannot be stalled; done marks them.
module wkv_recurrence_step_core #(
  parameter int CHANNELS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [9:0]         channel,
  input  logic signed [31:0] key_in,
  input  logic signed [31:0] value_in,
  input  logic signed [31:0] bonus,
  input  logic signed [31:0] decay,
  output logic               done,
  output logic [9:0]         channel_out,
  output logic signed [31:0] wkv_out,
  output logic               saturated
);

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RECIP = (2**21 + CHANNELS - 1) / CHANNELS;
  localparam bit WIDE  = (CHANNELS >= 1024);
  localparam int AL    = wkv_pkg::ARG_W;
  localparam int SW    = wkv_pkg::SUM_W;
  localparam int FB    = wkv_pkg::FRAC_BITS;

  wkv_pkg::core_state_t state, state_next;

  // Item registers.
  logic               act_r;
  logic [9:0]         ch_r;
  logic signed [31:0] k_r, v_r, u_r, w_r;
  logic [9:0]         quot_r;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      clr_cnt;

  // Channel state and exponent arithmetic.
  logic signed [31:0]   aa, bb, pp;
  logic signed [32:0]   uk, pw, qp;
  logic signed [AL-1:0] args [4];
  logic [wkv_pkg::EXP_W-1:0] e_r [4];
  logic [1:0]           ecnt;

  // Multiply-accumulate.
  logic [2:0]            mcnt;
  logic signed [49:0]    mprod;
  logic signed [SW-1:0]  num, den, na, nb;

  // Division.
  logic                          num_neg;
  logic [wkv_pkg::DIV_NW-1:0]    quot_q;

  // RAM ports.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [wkv_pkg::WORD_W-1:0]  ram_wdata;
  logic [wkv_pkg::WORD_W-1:0]  ram_rdata;

  // Sub-unit handshakes.
  logic                         exp_start, exp_done;
  logic [wkv_pkg::EXP_W-1:0]    exp_result;
  logic                         div_start, div_done;
  logic [wkv_pkg::DIV_NW-1:0]   div_q;

  // Combinational helpers.
  logic [31:0]            idx_prod;
  logic [31:0]            idx_rem;
  logic [AW-1:0]          idx;
  logic signed [32:0]     q_c;
  logic signed [32:0]     qp_c;
  logic [wkv_pkg::EXP_W-1:0] e_sel;
  logic signed [31:0]     op_sel;
  logic signed [SW-1:0]   den_sh;
  logic [wkv_pkg::DIV_DW-1:0] den_pos;
  logic signed [SW-1:0]   num_abs;
  logic signed [SW-1:0]   wkv_full;
  logic signed [SW-1:0]   na_sh, nb_sh;
  wkv_pkg::sat_t          wkv_s, aa_s, bb_s, pp_s;

  assign busy = (state != wkv_pkg::S_IDLE);

  // Channel index modulo CHANNELS through a reciprocal product.
  assign idx_prod = 32'(ch_r) * 32'(RECIP);
  assign idx_rem  = 32'(ch_r) - 32'(quot_r) * 32'(CHANNELS);
  assign idx      = WIDE ? AW'(ch_r) : AW'(idx_rem);

  // Maxima of the exponent terms.
  assign q_c  = (33'(pp) > uk) ? 33'(pp) : uk;
  assign qp_c = (pw > 33'(k_r)) ? pw : 33'(k_r);

  // Operands of the multiply-accumulate sequence.
  always_comb begin
    case (mcnt)
      3'd0:    begin e_sel = e_r[0]; op_sel = aa;  end
      3'd1:    begin e_sel = e_r[1]; op_sel = v_r; end
      3'd2:    begin e_sel = e_r[0]; op_sel = bb;  end
      3'd3:    begin e_sel = e_r[2]; op_sel = aa;  end
      3'd4:    begin e_sel = e_r[3]; op_sel = v_r; end
      3'd5:    begin e_sel = e_r[2]; op_sel = bb;  end
      default: begin e_sel = '0;     op_sel = '0;  end
    endcase
  end

  // Denominator floor-shifted and clamped to one LSB; numerator magnitude.
  assign den_sh  = den >>> FB;
  assign den_pos = (den_sh < SW'(1)) ? wkv_pkg::DIV_DW'(1) : den_sh[wkv_pkg::DIV_DW-1:0];
  assign num_abs = num[SW-1] ? -num : num;

  // Result and new state, saturated.
  assign wkv_full = num_neg ? -SW'(quot_q) : SW'(quot_q);
  assign na_sh    = na >>> FB;
  assign nb_sh    = nb >>> FB;
  assign wkv_s    = wkv_pkg::sat32(64'(wkv_full));
  assign aa_s     = wkv_pkg::sat32(64'(na_sh));
  assign bb_s     = wkv_pkg::sat32(64'(nb_sh));
  assign pp_s     = wkv_pkg::sat32(64'(qp));

  // RAM write: clearing sweep, clear item or state update.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = wkv_pkg::RESET_WORD;
    case (state)
      wkv_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      wkv_pkg::S_CLRW: begin
        ram_we = 1'b1;
      end
      wkv_pkg::S_OUT: begin
        ram_we    = 1'b1;
        ram_wdata = {pp_s.val, bb_s.val, aa_s.val};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign exp_start = (state == wkv_pkg::S_EXPGO);
  assign div_start = (state == wkv_pkg::S_DIVGO);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wkv_pkg::S_CLEAR: if (clr_cnt == AW'(CHANNELS - 1)) state_next = wkv_pkg::S_IDLE;
      wkv_pkg::S_IDLE:  if (start) state_next = wkv_pkg::S_QUOT;
      wkv_pkg::S_QUOT:  state_next = wkv_pkg::S_ADDR;
      wkv_pkg::S_ADDR: begin
        if (act_r == wkv_pkg::ACT_CLEAR) state_next = wkv_pkg::S_CLRW;
        else state_next = wkv_pkg::S_READ;
      end
      wkv_pkg::S_READ:  state_next = wkv_pkg::S_ARG;
      wkv_pkg::S_ARG:   state_next = wkv_pkg::S_ARG2;
      wkv_pkg::S_ARG2:  state_next = wkv_pkg::S_EXPGO;
      wkv_pkg::S_EXPGO: state_next = wkv_pkg::S_EXPW;
      wkv_pkg::S_EXPW: begin
        if (exp_done) begin
          if (ecnt == 2'd3) state_next = wkv_pkg::S_MACINIT;
          else state_next = wkv_pkg::S_EXPGO;
        end
      end
      wkv_pkg::S_MACINIT: state_next = wkv_pkg::S_MUL;
      wkv_pkg::S_MUL:     state_next = wkv_pkg::S_ACC;
      wkv_pkg::S_ACC: begin
        if (mcnt == 3'd5) state_next = wkv_pkg::S_DIVGO;
        else state_next = wkv_pkg::S_MUL;
      end
      wkv_pkg::S_DIVGO: state_next = wkv_pkg::S_DIVW;
      wkv_pkg::S_DIVW:  if (div_done) state_next = wkv_pkg::S_OUT;
      wkv_pkg::S_OUT:   state_next = wkv_pkg::S_IDLE;
      wkv_pkg::S_CLRW:  state_next = wkv_pkg::S_IDLE;
      default:          state_next = wkv_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= wkv_pkg::S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == wkv_pkg::S_OUT);
      if (state == wkv_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      wkv_pkg::S_IDLE: begin
        act_r <= action;
        ch_r  <= channel;
        k_r   <= key_in;
        v_r   <= value_in;
        u_r   <= bonus;
        w_r   <= decay;
      end
      wkv_pkg::S_QUOT: begin
        quot_r <= idx_prod[30:21];
        uk     <= 33'(u_r) + 33'(k_r);
      end
      wkv_pkg::S_ADDR: begin
        addr <= idx;
      end
      wkv_pkg::S_ARG: begin
        aa <= ram_rdata[31:0];
        bb <= ram_rdata[63:32];
        pp <= ram_rdata[95:64];
        pw <= 33'($signed(ram_rdata[95:64])) - 33'(w_r);
      end
      wkv_pkg::S_ARG2: begin
        args[0] <= AL'(pp) - AL'(q_c);
        args[1] <= AL'(uk) - AL'(q_c);
        args[2] <= AL'(pw) - AL'(qp_c);
        args[3] <= AL'(k_r) - AL'(qp_c);
        qp      <= qp_c;
        ecnt    <= 2'd0;
      end
      wkv_pkg::S_EXPW: begin
        if (exp_done) begin
          e_r[ecnt] <= exp_result;
          ecnt      <= ecnt + 2'd1;
        end
      end
      wkv_pkg::S_MACINIT: begin
        num  <= '0;
        na   <= '0;
        den  <= SW'(e_r[1]) << FB;
        nb   <= SW'(e_r[3]) << FB;
        mcnt <= 3'd0;
      end
      wkv_pkg::S_MUL: begin
        mprod <= 50'($signed({1'b0, e_sel}) * op_sel);
      end
      wkv_pkg::S_ACC: begin
        mcnt <= mcnt + 3'd1;
        case (mcnt)
          3'd0, 3'd1: num <= num + SW'(mprod);
          3'd2:       den <= den + SW'(mprod);
          3'd3, 3'd4: na  <= na + SW'(mprod);
          default:    nb  <= nb + SW'(mprod);
        endcase
      end
      wkv_pkg::S_DIVGO: begin
        num_neg <= num[SW-1];
      end
      wkv_pkg::S_DIVW: begin
        if (div_done) begin
          quot_q <= div_q;
        end
      end
      wkv_pkg::S_OUT: begin
        channel_out <= ch_r;
        wkv_out     <= wkv_s.val;
        saturated   <= wkv_s.flag | aa_s.flag | bb_s.flag | pp_s.flag;
      end
      default: begin
        act_r <= act_r;
      end
    endcase
  end

  wkv_ram #(
    .WIDTH(wkv_pkg::WORD_W),
    .DEPTH(CHANNELS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  wkv_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .arg   (args[ecnt]),
    .done  (exp_done),
    .result(exp_result)
  );

  wkv_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(num_abs[wkv_pkg::DIV_NW-1:0]),
    .divisor (den_pos),
    .done    (div_done),
    .quotient(div_q)
  );

`ifndef SYNTHESIS
  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted command makes the core busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  // The exp unit only finishes while the sequencer waits for it.
  a_exp_wait: assert property (@(posedge clk) disable iff (rst)
    exp_done |-> (state == wkv_pkg::S_EXPW))
    else $error("exp result outside its wait state");

  // The divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == wkv_pkg::S_DIVW))
    else $error("divider result outside its wait state");
`endif

endmodule
